// File: src/mqtt_pbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// MQTT packet byte parser package
// Parser state type, phase and string kind codes, field tags, error codes and
// the small next-state helpers shared by the parsing logic.
// -----------------------------------------------------------------------------
package mqtt_pbp_pkg;

	// Reset value of the expected protocol name ("MQTT").
	localparam logic [31:0] PROTO_NAME_RESET = 32'h4D51_5454;

	// Control packet types that have a parsed body.
	localparam logic [3:0] PT_CONNECT     = 4'd1;
	localparam logic [3:0] PT_PUBLISH     = 4'd3;
	localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
	localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;

	// Field tags.
	localparam logic [4:0] TAG_HDR       = 5'd0;
	localparam logic [4:0] TAG_LEN       = 5'd1;
	localparam logic [4:0] TAG_STRLEN    = 5'd2;
	localparam logic [4:0] TAG_PROTONAME = 5'd3;
	localparam logic [4:0] TAG_VER       = 5'd4;
	localparam logic [4:0] TAG_FLAGS     = 5'd5;
	localparam logic [4:0] TAG_KEEPALIVE = 5'd6;
	localparam logic [4:0] TAG_CLIENTID  = 5'd7;
	localparam logic [4:0] TAG_WILLTOPIC = 5'd8;
	localparam logic [4:0] TAG_WILLMSG   = 5'd9;
	localparam logic [4:0] TAG_USER      = 5'd10;
	localparam logic [4:0] TAG_PASS      = 5'd11;
	localparam logic [4:0] TAG_TOPIC     = 5'd12;
	localparam logic [4:0] TAG_PKTID     = 5'd13;
	localparam logic [4:0] TAG_PAYLOAD   = 5'd14;
	localparam logic [4:0] TAG_REQQOS    = 5'd15;
	localparam logic [4:0] TAG_UNPARSED  = 5'd16;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_LEN   = 3'd1;
	localparam logic [2:0] ERR_TRUNCATED = 3'd2;
	localparam logic [2:0] ERR_NAME      = 3'd3;
	localparam logic [2:0] ERR_BAD_QOS   = 3'd4;
	localparam logic [2:0] ERR_NO_TOPICS = 3'd5;

	// Connect flag bits.
	localparam int FLAG_WILL = 2;
	localparam int FLAG_PASS = 6;
	localparam int FLAG_USER = 7;

	typedef enum logic [3:0] {
		PH_HDR, PH_LEN, PH_TAIL, PH_VER, PH_FLAGS, PH_KA,
		PH_PID, PH_PAYLOAD, PH_QOS, PH_SLEN, PH_SBODY
	} phase_t;

	typedef enum logic [2:0] {
		K_PROTO, K_CLIENT, K_WTOPIC, K_WMSG, K_USER, K_PASS, K_TOPIC
	} kind_t;

	typedef struct packed {
		phase_t       ph;
		kind_t        kind;
		logic [7:0]   hdr;
		logic [27:0]  acc;
		logic [2:0]   lcnt;
		logic [27:0]  body;
		logic [15:0]  sl;
		logic [7:0]   cflags;
		logic [31:0]  nshift;
		logic [15:0]  ecnt;
		logic         errseen;
	} st_t;

	// Start a length-prefixed string of the given kind.
	function automatic st_t enter_string(st_t s, kind_t k);
		st_t r;
		r = s;
		r.ph = PH_SLEN;
		r.kind = k;
		r.sl = '0;
		return r;
	endfunction

	// Count one more topic entry, saturating.
	function automatic st_t bump_entry(st_t s);
		st_t r;
		r = s;
		if (s.ecnt != 16'hFFFF) begin
			r.ecnt = s.ecnt + 16'd1;
		end
		return r;
	endfunction

	function automatic st_t after_user(st_t s);
		st_t r;
		r = s;
		if (s.cflags[FLAG_PASS]) begin
			r = enter_string(s, K_PASS);
		end else begin
			r.ph = PH_TAIL;
		end
		return r;
	endfunction

	function automatic st_t after_will(st_t s);
		st_t r;
		if (s.cflags[FLAG_USER]) begin
			r = enter_string(s, K_USER);
		end else begin
			r = after_user(s);
		end
		return r;
	endfunction

	// Move on once the current string is complete.
	function automatic st_t string_done(st_t s);
		st_t r;
		r = s;
		unique case (s.kind)
			K_PROTO: r.ph = PH_VER;
			K_CLIENT: begin
				if (s.cflags[FLAG_WILL]) r = enter_string(s, K_WTOPIC);
				else r = after_will(s);
			end
			K_WTOPIC: r = enter_string(s, K_WMSG);
			K_WMSG: r = after_will(s);
			K_USER: r = after_user(s);
			K_PASS: r.ph = PH_TAIL;
			default: begin
				if (s.hdr[7:4] == PT_PUBLISH) begin
					if (s.hdr[2:1] != 2'd0) begin
						r.ph = PH_PID;
						r.sl = 16'd2;
					end else begin
						r.ph = PH_PAYLOAD;
					end
				end else if (s.hdr[7:4] == PT_SUBSCRIBE) begin
					r.ph = PH_QOS;
				end else begin
					r = enter_string(bump_entry(s), K_TOPIC);
				end
			end
		endcase
		return r;
	endfunction

	// First phase of the body after the last length byte.
	function automatic st_t body_start(st_t s);
		st_t r;
		r = s;
		if (s.hdr[7:4] == PT_CONNECT) begin
			r = enter_string(s, K_PROTO);
		end else if (s.hdr[7:4] == PT_PUBLISH) begin
			r = enter_string(s, K_TOPIC);
		end else if (s.hdr[7:4] == PT_SUBSCRIBE || s.hdr[7:4] == PT_UNSUBSCRIBE) begin
			r.ph = PH_PID;
			r.sl = 16'd2;
		end else begin
			r.ph = PH_TAIL;
		end
		return r;
	endfunction

	// Check that the packet ended at a legal point.
	function automatic logic [2:0] end_check(st_t s);
		logic [2:0] e;
		e = ERR_NONE;
		if (s.hdr[7:4] == PT_CONNECT) begin
			if (s.ph != PH_TAIL) e = ERR_TRUNCATED;
		end else if (s.hdr[7:4] == PT_PUBLISH) begin
			if (s.ph != PH_PAYLOAD) e = ERR_TRUNCATED;
		end else if (s.hdr[7:4] == PT_SUBSCRIBE || s.hdr[7:4] == PT_UNSUBSCRIBE) begin
			if (s.ph == PH_SLEN && s.kind == K_TOPIC) begin
				if (s.ecnt == 16'd0) e = ERR_NO_TOPICS;
			end else begin
				e = ERR_TRUNCATED;
			end
		end
		return e;
	endfunction

	// Tag of a body byte in the given parser position.
	function automatic logic [4:0] tag_of(st_t s);
		logic [4:0] t;
		t = TAG_UNPARSED;
		unique case (s.ph)
			PH_SLEN: t = TAG_STRLEN;
			PH_SBODY: begin
				unique case (s.kind)
					K_PROTO:  t = TAG_PROTONAME;
					K_CLIENT: t = TAG_CLIENTID;
					K_WTOPIC: t = TAG_WILLTOPIC;
					K_WMSG:   t = TAG_WILLMSG;
					K_USER:   t = TAG_USER;
					K_PASS:   t = TAG_PASS;
					default:  t = TAG_TOPIC;
				endcase
			end
			PH_VER:     t = TAG_VER;
			PH_FLAGS:   t = TAG_FLAGS;
			PH_KA:      t = TAG_KEEPALIVE;
			PH_PID:     t = TAG_PKTID;
			PH_PAYLOAD: t = TAG_PAYLOAD;
			PH_QOS:     t = TAG_REQQOS;
			default:    t = TAG_UNPARSED;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// File: src/mqtt_packet_byte_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// MQTT packet byte parser
// Tags every byte of an MQTT 3.1.1 control packet stream with its field, the
// decoded fixed header, the remaining length, the topic entry and any error.
//
// Use: bytes enter on the in_valid/in_ready channel, one item per byte. Every
// byte yields exactly one result item on the out_valid/out_ready channel.
// An accepted byte sits in the input register while the parser state is
// updated, and its result is loaded into the output register as soon as
// that register is free. One byte is taken in every cycle while the receiver
// keeps up; the rate is set by the single parser state update per byte.
// When the receiver stalls, the result stays in the output register and one
// more byte is held in the input register; in_ready then falls until the
// output is taken. Reset empties both registers and puts the parser at the
// start of a packet, expecting a header byte; the protocol name register
// returns to "MQTT". cfg_wr_en writes the protocol name from cfg_wr_data at
// once and is to be used only while no item is in flight.
// -----------------------------------------------------------------------------
module mqtt_packet_byte_parser
	import mqtt_pbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       byte_out,
	output logic [4:0]       field_tag,
	output logic [3:0]       packet_type,
	output logic             dup_flag,
	output logic [1:0]       qos_level,
	output logic             retain_flag,
	output logic [27:0]      decoded_length,
	output logic [15:0]      entry_index,
	output logic             packet_end,
	output logic [2:0]       error_code,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic [31:0] proto_name_q;
	st_t         st_q;
	st_t         n;
	logic [4:0]  r_tag;
	logic [2:0]  r_err;
	logic        r_end;
	logic [15:0] r_eidx;
	logic [15:0] len;

	// Handshake: the input register moves on when the output register is free.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Protocol name register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_name_q <= PROTO_NAME_RESET;
		end else if (cfg_wr_en) begin
			proto_name_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// Parser step for the byte in the input register.
	always_comb begin
		n      = st_q;
		r_tag  = TAG_UNPARSED;
		r_err  = ERR_NONE;
		r_end  = 1'b0;
		r_eidx = st_q.ecnt;
		len    = {st_q.sl[15:8], byte_s1};
		if (st_q.ph == PH_HDR) begin
			n.hdr     = byte_s1;
			n.acc     = '0;
			n.lcnt    = '0;
			n.body    = '0;
			n.sl      = '0;
			n.cflags  = '0;
			n.nshift  = '0;
			n.ecnt    = '0;
			n.errseen = 1'b0;
			n.ph      = PH_LEN;
			r_tag     = TAG_HDR;
			r_eidx    = '0;
		end else if (st_q.ph == PH_LEN) begin
			r_tag = TAG_LEN;
			if (st_q.lcnt >= 3'd4) begin
				r_err = ERR_BAD_LEN;
				r_end = 1'b1;
				n.ph  = PH_HDR;
			end else begin
				case (st_q.lcnt[1:0])
					2'd0:    n.acc = st_q.acc | {21'd0, byte_s1[6:0]};
					2'd1:    n.acc = st_q.acc | {14'd0, byte_s1[6:0], 7'd0};
					2'd2:    n.acc = st_q.acc | {7'd0, byte_s1[6:0], 14'd0};
					default: n.acc = st_q.acc | {byte_s1[6:0], 21'd0};
				endcase
				n.lcnt = st_q.lcnt + 3'd1;
				if (!byte_s1[7]) begin
					n.body = n.acc;
					n = body_start(n);
					if (n.acc == 28'd0) begin
						r_err = end_check(n);
						r_end = 1'b1;
						n.ph  = PH_HDR;
					end
				end
			end
		end else begin
			r_tag  = st_q.errseen ? TAG_UNPARSED : tag_of(st_q);
			n.body = st_q.body - 28'd1;
			if (!st_q.errseen) begin
				// Field walk for one body byte.
				case (st_q.ph)
					PH_SBODY: begin
						if (st_q.kind == K_PROTO) begin
							n.nshift = {st_q.nshift[23:0], byte_s1};
						end
						n.sl = st_q.sl - 16'd1;
						if (n.sl == 16'd0) begin
							if (st_q.kind == K_PROTO && n.nshift != proto_name_q) begin
								r_err = ERR_NAME;
							end else begin
								n = string_done(n);
							end
						end
					end
					PH_SLEN: begin
						if (!st_q.sl[0]) begin
							n.sl = {byte_s1, 8'h01};
						end else if (st_q.kind == K_PROTO && len != 16'd4) begin
							r_err = ERR_NAME;
						end else begin
							n.sl = len;
							if (len == 16'd0) n = string_done(n);
							else n.ph = PH_SBODY;
						end
					end
					PH_VER: n.ph = PH_FLAGS;
					PH_FLAGS: begin
						n.cflags = byte_s1;
						n.ph     = PH_KA;
						n.sl     = 16'd2;
					end
					PH_KA: begin
						n.sl = st_q.sl - 16'd1;
						if (n.sl == 16'd0) n = enter_string(n, K_CLIENT);
					end
					PH_PID: begin
						n.sl = st_q.sl - 16'd1;
						if (n.sl == 16'd0) begin
							if (st_q.hdr[7:4] == PT_PUBLISH) n.ph = PH_PAYLOAD;
							else n = enter_string(n, K_TOPIC);
						end
					end
					PH_QOS: begin
						if (byte_s1 > 8'd2) r_err = ERR_BAD_QOS;
						else n = enter_string(bump_entry(n), K_TOPIC);
					end
					default: ;
				endcase
				if (r_err != ERR_NONE) n.errseen = 1'b1;
			end
			if (n.body == 28'd0) begin
				if (!n.errseen) r_err = end_check(n);
				r_end = 1'b1;
				n.ph  = PH_HDR;
			end
		end
	end

	// Parser state, updated as each item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{ph: PH_HDR, kind: K_PROTO, default: '0};
		end else if (advance) begin
			st_q <= n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_out       <= byte_s1;
			field_tag      <= r_tag;
			packet_type    <= n.hdr[7:4];
			dup_flag       <= n.hdr[3];
			qos_level      <= n.hdr[2:1];
			retain_flag    <= n.hdr[0];
			decoded_length <= n.acc;
			entry_index    <= r_eidx;
			packet_end     <= r_end;
			error_code     <= r_err;
		end
	end

	// A bad length always ends the packet on a length byte.
	a_bad_len_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_BAD_LEN |-> packet_end && field_tag == TAG_LEN)
		else $error("bad length result without packet end");

	// A header byte starts with a clean length, entry and error.
	a_hdr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_tag == TAG_HDR |->
			decoded_length == 28'd0 && entry_index == 16'd0 && error_code == ERR_NONE)
		else $error("header byte with stale fields");

	// A qos error is only raised on a requested qos byte.
	a_qos_on_reqqos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_BAD_QOS |-> field_tag == TAG_REQQOS)
		else $error("qos error on wrong field");

	// The length byte count never runs past the error byte.
	a_lcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.lcnt <= 3'd4)
		else $error("length byte count out of range");

endmodule
`default_nettype wire

// File: verif/mqtt_packet_byte_parser_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// MQTT packet byte parser testbench
// Sends streams of CONNECT, PUBLISH, SUBSCRIBE, UNSUBSCRIBE and other packets,
// whole, truncated and with broken length encodings, and checks every tagged
// result item against a behavioural model of the parser kept in the bench.
// -----------------------------------------------------------------------------
module mqtt_packet_byte_parser_tb;
	import mqtt_pbp_pkg::*;

	localparam int RANDOM_ITEMS = 650;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  byte_out;
	logic [4:0]  field_tag;
	logic [3:0]  packet_type;
	logic        dup_flag;
	logic [1:0]  qos_level;
	logic        retain_flag;
	logic [27:0] decoded_length;
	logic [15:0] entry_index;
	logic        packet_end;
	logic [2:0]  error_code;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	typedef struct {
		logic [7:0]  byte_v;
		logic [4:0]  tag;
		logic [3:0]  ptype;
		logic        dup;
		logic [1:0]  qos;
		logic        ret;
		logic [27:0] rlen;
		logic [15:0] eidx;
		logic        pend;
		logic [2:0]  err;
	} tagged_byte_t;

	tagged_byte_t expected_tags[$];
	logic [7:0]   body_q[$];

	int fail_count;
	int checked_count;
	int sent_count;
	int packet_count;
	int send_idle_pct;
	int recv_idle_pct;

	// Parser model state.
	phase_t      m_ph;
	kind_t       m_kind;
	logic [7:0]  m_hdr;
	logic [27:0] m_acc;
	int          m_lcnt;
	logic [27:0] m_body;
	logic [15:0] m_str;
	logic [7:0]  m_cflags;
	logic [31:0] m_name;
	logic [15:0] m_ecnt;
	logic        m_err;
	logic [31:0] m_word;

	mqtt_packet_byte_parser uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.byte_out(byte_out), .field_tag(field_tag), .packet_type(packet_type),
		.dup_flag(dup_flag), .qos_level(qos_level), .retain_flag(retain_flag),
		.decoded_length(decoded_length), .entry_index(entry_index),
		.packet_end(packet_end), .error_code(error_code),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	// The run is cut short if it hangs.
	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	// Model helpers for the string walk.
	task automatic start_str(input kind_t k);
		m_ph = PH_SLEN;
		m_kind = k;
		m_str = '0;
	endtask

	task automatic count_entry();
		if (m_ecnt != 16'hFFFF) m_ecnt = m_ecnt + 16'd1;
	endtask

	task automatic next_after_user();
		if (m_cflags[6]) start_str(K_PASS);
		else m_ph = PH_TAIL;
	endtask

	task automatic next_after_will();
		if (m_cflags[7]) start_str(K_USER);
		else next_after_user();
	endtask

	task automatic finish_string();
		case (m_kind)
			K_PROTO: m_ph = PH_VER;
			K_CLIENT: begin
				if (m_cflags[2]) start_str(K_WTOPIC);
				else next_after_will();
			end
			K_WTOPIC: start_str(K_WMSG);
			K_WMSG: next_after_will();
			K_USER: next_after_user();
			K_PASS: m_ph = PH_TAIL;
			default: begin
				if (m_hdr[7:4] == PT_PUBLISH) begin
					if (m_hdr[2:1] != 2'd0) begin
						m_ph = PH_PID;
						m_str = 16'd2;
					end else begin
						m_ph = PH_PAYLOAD;
					end
				end else if (m_hdr[7:4] == PT_SUBSCRIBE) begin
					m_ph = PH_QOS;
				end else begin
					count_entry();
					start_str(K_TOPIC);
				end
			end
		endcase
	endtask

	// Error for a packet that ends in the current position.
	function automatic logic [2:0] ending_error();
		logic [2:0] e;
		e = ERR_NONE;
		case (m_hdr[7:4])
			PT_CONNECT: if (m_ph != PH_TAIL) e = ERR_TRUNCATED;
			PT_PUBLISH: if (m_ph != PH_PAYLOAD) e = ERR_TRUNCATED;
			PT_SUBSCRIBE, PT_UNSUBSCRIBE: begin
				if (m_ph == PH_SLEN && m_kind == K_TOPIC) begin
					if (m_ecnt == 16'd0) e = ERR_NO_TOPICS;
				end else begin
					e = ERR_TRUNCATED;
				end
			end
			default: e = ERR_NONE;
		endcase
		return e;
	endfunction

	// Works out the tagged result for one accepted byte and queues it.
	task automatic predict_byte(input logic [7:0] b);
		tagged_byte_t r;
		logic [2:0]   err;
		logic         pend;
		logic [15:0]  eidx;
		logic [4:0]   tag;
		logic [15:0]  len;
		err = ERR_NONE;
		pend = 1'b0;
		eidx = m_ecnt;
		if (m_ph == PH_HDR) begin
			m_hdr = b;
			m_acc = '0;
			m_lcnt = 0;
			m_body = '0;
			m_str = '0;
			m_cflags = '0;
			m_name = '0;
			m_ecnt = '0;
			m_err = 1'b0;
			m_ph = PH_LEN;
			tag = TAG_HDR;
			eidx = '0;
		end else if (m_ph == PH_LEN) begin
			tag = TAG_LEN;
			if (m_lcnt >= 4) begin
				err = ERR_BAD_LEN;
				pend = 1'b1;
				m_ph = PH_HDR;
			end else begin
				m_acc = m_acc | (28'(b[6:0]) << (7 * m_lcnt));
				m_lcnt++;
				if (!b[7]) begin
					m_body = m_acc;
					case (m_hdr[7:4])
						PT_CONNECT: start_str(K_PROTO);
						PT_PUBLISH: start_str(K_TOPIC);
						PT_SUBSCRIBE, PT_UNSUBSCRIBE: begin
							m_ph = PH_PID;
							m_str = 16'd2;
						end
						default: m_ph = PH_TAIL;
					endcase
					if (m_body == 0) begin
						err = ending_error();
						pend = 1'b1;
						m_ph = PH_HDR;
					end
				end
			end
		end else begin
			// Field tag of a body byte follows the position before the update.
			case (m_ph)
				PH_SLEN: tag = TAG_STRLEN;
				PH_SBODY: begin
					case (m_kind)
						K_PROTO:  tag = TAG_PROTONAME;
						K_CLIENT: tag = TAG_CLIENTID;
						K_WTOPIC: tag = TAG_WILLTOPIC;
						K_WMSG:   tag = TAG_WILLMSG;
						K_USER:   tag = TAG_USER;
						K_PASS:   tag = TAG_PASS;
						default:  tag = TAG_TOPIC;
					endcase
				end
				PH_VER:     tag = TAG_VER;
				PH_FLAGS:   tag = TAG_FLAGS;
				PH_KA:      tag = TAG_KEEPALIVE;
				PH_PID:     tag = TAG_PKTID;
				PH_PAYLOAD: tag = TAG_PAYLOAD;
				PH_QOS:     tag = TAG_REQQOS;
				default:    tag = TAG_UNPARSED;
			endcase
			if (m_err) tag = TAG_UNPARSED;
			m_body = m_body - 28'd1;
			if (!m_err) begin
				case (m_ph)
					PH_SBODY: begin
						if (m_kind == K_PROTO) m_name = {m_name[23:0], b};
						m_str = m_str - 16'd1;
						if (m_str == 0) begin
							if (m_kind == K_PROTO && m_name != m_word) err = ERR_NAME;
							else finish_string();
						end
					end
					PH_SLEN: begin
						if (!m_str[0]) begin
							m_str = {b, 8'h01};
						end else begin
							len = {m_str[15:8], b};
							if (m_kind == K_PROTO && len != 16'd4) begin
								err = ERR_NAME;
							end else begin
								m_str = len;
								if (len == 0) finish_string();
								else m_ph = PH_SBODY;
							end
						end
					end
					PH_VER: m_ph = PH_FLAGS;
					PH_FLAGS: begin
						m_cflags = b;
						m_ph = PH_KA;
						m_str = 16'd2;
					end
					PH_KA: begin
						m_str = m_str - 16'd1;
						if (m_str == 0) start_str(K_CLIENT);
					end
					PH_PID: begin
						m_str = m_str - 16'd1;
						if (m_str == 0) begin
							if (m_hdr[7:4] == PT_PUBLISH) m_ph = PH_PAYLOAD;
							else start_str(K_TOPIC);
						end
					end
					PH_QOS: begin
						if (b > 8'd2) begin
							err = ERR_BAD_QOS;
						end else begin
							count_entry();
							start_str(K_TOPIC);
						end
					end
					default: ;
				endcase
				if (err != ERR_NONE) m_err = 1'b1;
			end
			if (m_body == 0) begin
				if (!m_err) err = ending_error();
				pend = 1'b1;
				m_ph = PH_HDR;
			end
		end
		r.byte_v = b;
		r.tag = tag;
		r.ptype = m_hdr[7:4];
		r.dup = m_hdr[3];
		r.qos = m_hdr[2:1];
		r.ret = m_hdr[0];
		r.rlen = m_acc;
		r.eidx = eidx;
		r.pend = pend;
		r.err = err;
		expected_tags.push_back(r);
	endtask

	// Sends one item and records its expected result once it is accepted.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_byte(b);
		sent_count++;
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_tags.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_name(input logic [31:0] w);
		wait_drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		m_word = w;
		@(posedge clk);
	endtask

	// Sends header, remaining length and the body held in body_q.
	task automatic send_packet(input logic [7:0] hdr, input bit may_cut);
		int n;
		if (may_cut && body_q.size() > 0 && $urandom_range(4) == 0) begin
			n = $urandom_range(body_q.size() - 1);
			while (body_q.size() > n) void'(body_q.pop_back());
		end
		n = body_q.size();
		send_byte(hdr);
		do begin
			send_byte({(n > 127), 7'(n)});
			n = n >> 7;
		end while (n > 0);
		foreach (body_q[i]) send_byte(body_q[i]);
		body_q.delete();
		packet_count++;
	endtask

	task automatic send_raw(input logic [7:0] bytes[]);
		foreach (bytes[i]) send_byte(bytes[i]);
		packet_count++;
	endtask

	task automatic put_str(input int n);
		body_q.push_back(8'(n >> 8));
		body_q.push_back(8'(n));
		repeat (n) body_q.push_back(8'($urandom));
	endtask

	task automatic put_rand(input int n);
		repeat (n) body_q.push_back(8'($urandom));
	endtask

	task automatic build_connect();
		logic [7:0] flags;
		if ($urandom_range(7) == 0) begin
			put_rand(2);
		end else begin
			body_q.push_back(8'h00);
			body_q.push_back(8'h04);
		end
		if ($urandom_range(5) == 0) begin
			put_rand(4);
		end else begin
			for (int i = 3; i >= 0; i--) body_q.push_back(m_word[8 * i +: 8]);
		end
		flags = 8'($urandom);
		put_rand(1);
		body_q.push_back(flags);
		put_rand(2);
		put_str($urandom_range(5));
		if (flags[2]) begin
			put_str($urandom_range(4));
			put_str($urandom_range(4));
		end
		if (flags[7]) put_str($urandom_range(4));
		if (flags[6]) put_str($urandom_range(4));
		put_rand($urandom_range(2));
		send_packet({PT_CONNECT, 4'($urandom)}, 1'b1);
	endtask

	task automatic build_publish();
		logic [3:0] low;
		low = 4'($urandom);
		put_str($urandom_range(6));
		if (low[2:1] != 2'd0) put_rand(2);
		put_rand($urandom_range(8));
		send_packet({PT_PUBLISH, low}, 1'b1);
	endtask

	task automatic build_topic_list(input bit with_qos);
		put_rand(2);
		repeat ($urandom_range(4)) begin
			put_str($urandom_range(5));
			if (with_qos) begin
				if ($urandom_range(7) == 0) put_rand(1);
				else body_q.push_back(8'($urandom_range(2)));
			end
		end
		if ($urandom_range(5) == 0) put_rand(1);
		send_packet({(with_qos ? PT_SUBSCRIBE : PT_UNSUBSCRIBE), 4'($urandom)}, 1'b1);
	endtask

	task automatic build_other();
		logic [3:0] t;
		do t = 4'($urandom);
		while (t == PT_CONNECT || t == PT_PUBLISH || t == PT_SUBSCRIBE
			|| t == PT_UNSUBSCRIBE);
		put_rand($urandom_range(6));
		send_packet({t, 4'($urandom)}, 1'b0);
	endtask

	// Four length bytes that all continue, then a fifth.
	task automatic build_bad_length();
		logic [7:0] seq[];
		seq = new[6];
		seq[0] = 8'($urandom);
		for (int i = 1; i < 5; i++) seq[i] = 8'($urandom) | 8'h80;
		seq[5] = 8'($urandom);
		send_raw(seq);
	endtask

	task automatic run_random(input int items);
		int stop_at;
		int pick;
		stop_at = sent_count + items;
		while (sent_count < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 25) build_connect();
			else if (pick < 50) build_publish();
			else if (pick < 70) build_topic_list(1'b1);
			else if (pick < 82) build_topic_list(1'b0);
			else if (pick < 90) build_other();
			else build_bad_length();
		end
	endtask

	// Compares one field of a result and reports a mismatch.
	function automatic void check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// Checks each result item against the oldest expectation.
	always @(posedge clk) begin
		tagged_byte_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_tags.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual byte %0h",
						$time, byte_out);
					fail_count++;
				end else begin
					e = expected_tags.pop_front();
					check_field("byte_out", e.byte_v, byte_out);
					check_field("field_tag", e.tag, field_tag);
					check_field("packet_type", e.ptype, packet_type);
					check_field("dup_flag", e.dup, dup_flag);
					check_field("qos_level", e.qos, qos_level);
					check_field("retain_flag", e.ret, retain_flag);
					check_field("decoded_length", e.rlen, decoded_length);
					check_field("entry_index", e.eidx, entry_index);
					check_field("packet_end", e.pend, packet_end);
					check_field("error_code", e.err, error_code);
					checked_count++;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic test_reset();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		m_ph = PH_HDR;
		m_kind = K_PROTO;
		m_hdr = '0;
		m_acc = '0;
		m_lcnt = 0;
		m_body = '0;
		m_str = '0;
		m_cflags = '0;
		m_name = '0;
		m_ecnt = '0;
		m_err = 1'b0;
		m_word = PROTO_NAME_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Short hand-made packets covering the corner cases.
	task automatic test_directed();
		send_idle_pct = 13;
		recv_idle_pct = 78;
		// PUBLISH with an empty topic and no payload.
		send_raw('{8'h30, 8'h02, 8'h00, 8'h00});
		// Fifth length byte, then a new header straight after.
		send_raw('{8'hC0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
		// SUBSCRIBE with no topic entry.
		send_raw('{8'h82, 8'h02, 8'h00, 8'h01});
		// SUBSCRIBE asking for qos 3.
		send_raw('{8'h82, 8'h06, 8'h00, 8'h01, 8'h00, 8'h01, 8'h61, 8'h03});
		// CONNECT with an empty body.
		send_raw('{8'h10, 8'h00});
		// CONNECT with a protocol name of the wrong length.
		send_raw('{8'h10, 8'h02, 8'h00, 8'h05});
	endtask

	task automatic test_random_traffic();
		send_idle_pct = 13;
		recv_idle_pct = 78;
		run_random(RANDOM_ITEMS / 6);
		// Hold off until all results are in, then carry on.
		wait_drain();
		run_random(RANDOM_ITEMS / 6);
		write_name(32'hFFFF_FFFF);
		send_idle_pct = 78;
		recv_idle_pct = 13;
		run_random(RANDOM_ITEMS / 6);
		write_name(32'h0000_0000);
		run_random(RANDOM_ITEMS / 6);
		write_name($urandom);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(RANDOM_ITEMS / 6);
		write_name(PROTO_NAME_RESET);
		run_random(RANDOM_ITEMS / 6);
	endtask

	initial begin
		fail_count = 0;
		checked_count = 0;
		sent_count = 0;
		packet_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_reset();
		test_directed();
		test_random_traffic();
		wait_drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d packets as %0d bytes and checked %0d tagged results,",
			packet_count, sent_count, checked_count);
		$display("over several protocol names and with stalls on either side.");
		if (fail_count == 0 && expected_tags.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/mqtt_pbp_pkg.sv
src/mqtt_packet_byte_parser.sv
verif/mqtt_packet_byte_parser_tb.sv
